// ----- hdl/debug_module_breakpoint_unit_defines.svh -----
// Assertion helpers used by the top-level RTL file
`ifndef DEBUG_MODULE_BREAKPOINT_UNIT_DEFINES_SVH
`define DEBUG_MODULE_BREAKPOINT_UNIT_DEFINES_SVH

// check that a condition implies another in the same cycle
`define DMBU_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// check that a condition implies another in the following cycle
`define DMBU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dmbu_pkg.sv -----
package dmbu_pkg;

    typedef enum logic [2:0] {
        OP_HALT      = 3'd0,
        OP_RESUME    = 3'd1,
        OP_STEP      = 3'd2,
        OP_SET_BP    = 3'd3,
        OP_CLEAR_BP  = 3'd4,
        OP_CHECK_HIT = 3'd5,
        OP_ABSTRACT  = 3'd6
    } dmbu_op_t;

    typedef enum logic [1:0] {
        MODE_RUNNING  = 2'd0,
        MODE_HALTED   = 2'd1,
        MODE_STEPPING = 2'd2
    } dmbu_mode_t;

    localparam int unsigned ARG_REGNO_MSB = 7;
    localparam int unsigned ARG_WRITE_BIT = 16;
    localparam int unsigned ARG_VALUE_LSB = 24;
    localparam int unsigned ARG_VALUE_MSB = 31;

    typedef struct packed {
        logic capture;
        logic execute;
    } dmbu_cmd_t;

endpackage

// ----- hdl/dmbu_ctrl.sv -----
module dmbu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output dmbu_pkg::dmbu_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;

    assign s_ready     = (state_reg == ST_IDLE) || (m_valid_reg && m_ready);
    assign accept      = s_valid && s_ready;
    assign cmd.capture = accept;
    assign cmd.execute = (state_reg == ST_EXEC);
    assign m_valid     = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next   = ST_RESP;
                m_valid_next = 1'b1;
            end
            ST_RESP: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- hdl/dmbu_dpath.sv -----
module dmbu_dpath #(
    parameter int unsigned SLOT_COUNT = 8,
    parameter int unsigned REG_COUNT  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dmbu_pkg::dmbu_cmd_t cmd,
    input  logic                cfg_write,
    input  logic [31:0]         cfg_data,
    input  logic [2:0]          s_operation,
    input  logic [31:0]         s_address,
    input  logic                s_is_instruction,
    input  logic [3:0]          s_slot_index,
    input  logic [31:0]         s_command,
    input  logic [31:0]         s_argument,
    output logic                m_ok,
    output logic [2:0]          m_slot_given,
    output logic [7:0]          m_read_data,
    output logic                m_read_valid,
    output logic [1:0]          m_run_state,
    output logic                m_halted_flag,
    output logic                m_resume_seen,
    output logic [31:0]         m_captured_pc
);

    localparam int unsigned CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int unsigned SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned REG_AW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int unsigned CMP_W   = (CNT_W > 4) ? CNT_W : 4;

    logic [31:0]          acc_cmd_reg;
    dmbu_pkg::dmbu_op_t   op_reg;
    logic [31:0]          addr_reg;
    logic                 kind_reg;
    logic [3:0]           sidx_reg;
    logic [31:0]          command_reg;
    logic [31:0]          arg_reg;

    dmbu_pkg::dmbu_mode_t mode_reg;
    dmbu_pkg::dmbu_mode_t mode_next;
    logic                 halted_reg;
    logic                 halted_next;
    logic                 resume_reg;
    logic                 resume_next;
    logic [31:0]          pc_reg;
    logic [31:0]          pc_next;
    logic [CNT_W-1:0]     used_reg;
    logic [CNT_W-1:0]     used_next;
    logic [SLOT_COUNT-1:0] slot_en_reg;
    logic [SLOT_COUNT-1:0] slot_en_next;
    logic [SLOT_COUNT-1:0] slot_kind_reg;
    logic [31:0]          slot_addr_reg [SLOT_COUNT];

    logic                 ok_reg;
    logic                 ok_next;
    logic [2:0]           given_reg;
    logic [2:0]           given_next;
    logic                 rvalid_reg;
    logic                 rvalid_next;

    logic [7:0]           dreg_mem [REG_COUNT];
    logic [REG_COUNT-1:0] dreg_vld_reg;
    logic [7:0]           mem_rd_reg;
    logic                 mem_hit_reg;

    logic                 alloc;
    logic                 hit;
    logic                 is_access;
    logic                 regno_ok;
    logic                 reg_write;
    logic [REG_AW-1:0]    reg_idx;
    logic [SLOT_AW-1:0]   alloc_idx;
    logic [SLOT_AW-1:0]   clear_idx;

    assign is_access = (command_reg == acc_cmd_reg);
    assign regno_ok  = {1'b0, arg_reg[dmbu_pkg::ARG_REGNO_MSB:0]} < 9'(REG_COUNT);
    assign reg_idx   = arg_reg[REG_AW-1:0];
    assign alloc_idx = used_reg[SLOT_AW-1:0];
    assign clear_idx = sidx_reg[SLOT_AW-1:0];
    assign reg_write = cmd.execute && (op_reg == dmbu_pkg::OP_ABSTRACT) && is_access
                       && regno_ok && arg_reg[dmbu_pkg::ARG_WRITE_BIT];

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_en_reg[i] && (slot_addr_reg[i] == addr_reg)
                && (slot_kind_reg[i] == kind_reg)) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        halted_next  = halted_reg;
        resume_next  = resume_reg;
        pc_next      = pc_reg;
        used_next    = used_reg;
        slot_en_next = slot_en_reg;
        ok_next      = 1'b0;
        given_next   = 3'd0;
        rvalid_next  = 1'b0;
        alloc        = 1'b0;
        case (op_reg)
            dmbu_pkg::OP_HALT: begin
                mode_next   = dmbu_pkg::MODE_HALTED;
                halted_next = 1'b1;
                pc_next     = addr_reg;
                ok_next     = 1'b1;
            end
            dmbu_pkg::OP_RESUME: begin
                mode_next   = dmbu_pkg::MODE_RUNNING;
                halted_next = 1'b0;
                resume_next = 1'b1;
                ok_next     = 1'b1;
            end
            dmbu_pkg::OP_STEP: begin
                mode_next   = dmbu_pkg::MODE_STEPPING;
                halted_next = 1'b1;
                pc_next     = addr_reg;
                ok_next     = 1'b1;
            end
            dmbu_pkg::OP_SET_BP: begin
                if (used_reg != CNT_W'(SLOT_COUNT)) begin
                    alloc                   = 1'b1;
                    slot_en_next[alloc_idx] = 1'b1;
                    used_next               = used_reg + CNT_W'(1);
                    given_next              = 3'(used_reg);
                    ok_next                 = 1'b1;
                end
            end
            dmbu_pkg::OP_CLEAR_BP: begin
                if (CMP_W'(sidx_reg) < CMP_W'(used_reg)) begin
                    slot_en_next[clear_idx] = 1'b0;
                    ok_next                 = 1'b1;
                end
            end
            dmbu_pkg::OP_CHECK_HIT: begin
                ok_next = hit;
            end
            dmbu_pkg::OP_ABSTRACT: begin
                if (is_access) begin
                    ok_next     = 1'b1;
                    rvalid_next = regno_ok && !arg_reg[dmbu_pkg::ARG_WRITE_BIT];
                end
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_cmd_reg  <= 32'd0;
            mode_reg     <= dmbu_pkg::MODE_RUNNING;
            halted_reg   <= 1'b0;
            resume_reg   <= 1'b0;
            pc_reg       <= 32'd0;
            used_reg     <= '0;
            slot_en_reg  <= '0;
            dreg_vld_reg <= '0;
        end else begin
            if (cfg_write) begin
                acc_cmd_reg <= cfg_data;
            end
            if (cmd.execute) begin
                mode_reg    <= mode_next;
                halted_reg  <= halted_next;
                resume_reg  <= resume_next;
                pc_reg      <= pc_next;
                used_reg    <= used_next;
                slot_en_reg <= slot_en_next;
            end
            if (reg_write) begin
                dreg_vld_reg[reg_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= dmbu_pkg::dmbu_op_t'(s_operation);
            addr_reg    <= s_address;
            kind_reg    <= s_is_instruction;
            sidx_reg    <= s_slot_index;
            command_reg <= s_command;
            arg_reg     <= s_argument;
        end
        if (cmd.execute) begin
            ok_reg      <= ok_next;
            given_reg   <= given_next;
            rvalid_reg  <= rvalid_next;
            mem_rd_reg  <= dreg_mem[reg_idx];
            mem_hit_reg <= dreg_vld_reg[reg_idx];
        end
        if (alloc && cmd.execute) begin
            slot_addr_reg[alloc_idx] <= addr_reg;
            slot_kind_reg[alloc_idx] <= kind_reg;
        end
        if (reg_write) begin
            dreg_mem[reg_idx] <= arg_reg[dmbu_pkg::ARG_VALUE_MSB:dmbu_pkg::ARG_VALUE_LSB];
        end
    end

    assign m_ok          = ok_reg;
    assign m_slot_given  = given_reg;
    assign m_read_valid  = rvalid_reg;
    assign m_read_data   = (rvalid_reg && mem_hit_reg) ? mem_rd_reg : 8'd0;
    assign m_run_state   = mode_reg;
    assign m_halted_flag = halted_reg;
    assign m_resume_seen = resume_reg;
    assign m_captured_pc = pc_reg;

endmodule

// ----- hdl/debug_module_breakpoint_unit.sv -----
// Flow: an accepted item is held in the capture register, executed in the execute
// state, and its registered result is then shown with m_valid until it is taken.
// Overlap: no item is accepted while one executes; the next item is accepted at the edge
// the current result is taken, set by the capture register ahead of the single execute state.
// Reset: aresetn is synchronous, active low; clears run state, slots, the access
// command code and the debug registers (by per-entry valid bits).
`include "debug_module_breakpoint_unit_defines.svh"

module debug_module_breakpoint_unit #(
    parameter int unsigned SLOT_COUNT = 8,
    parameter int unsigned REG_COUNT  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_address,
    input  logic        s_is_instruction,
    input  logic [3:0]  s_slot_index,
    input  logic [31:0] s_command,
    input  logic [31:0] s_argument,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [2:0]  m_slot_given,
    output logic [7:0]  m_read_data,
    output logic        m_read_valid,
    output logic [1:0]  m_run_state,
    output logic        m_halted_flag,
    output logic        m_resume_seen,
    output logic [31:0] m_captured_pc
);

    dmbu_pkg::dmbu_cmd_t cmd;

    assign cfg_ready = 1'b1;

    dmbu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dmbu_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .REG_COUNT  (REG_COUNT)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .s_operation      (s_operation),
        .s_address        (s_address),
        .s_is_instruction (s_is_instruction),
        .s_slot_index     (s_slot_index),
        .s_command        (s_command),
        .s_argument       (s_argument),
        .m_ok             (m_ok),
        .m_slot_given     (m_slot_given),
        .m_read_data      (m_read_data),
        .m_read_valid     (m_read_valid),
        .m_run_state      (m_run_state),
        .m_halted_flag    (m_halted_flag),
        .m_resume_seen    (m_resume_seen),
        .m_captured_pc    (m_captured_pc)
    );

    `DMBU_ASSERT_SAME(a_halted_matches_mode, aclk, aresetn, m_valid,
        (m_halted_flag == (m_run_state != dmbu_pkg::MODE_RUNNING)),
        "halted flag disagrees with run state")
    `DMBU_ASSERT_SAME(a_read_implies_ok, aclk, aresetn, m_valid && m_read_valid, m_ok,
        "read valid without recognized command")
    `DMBU_ASSERT_NEXT(a_no_result_after_accept, aclk, aresetn, s_valid && s_ready, !m_valid,
        "result shown in the cycle after accept")

endmodule
